### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also runs through reset
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

    // Default sizing
    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;

    // Window length register
    localparam int LEN_BITS  = 7;
    localparam int LEN_RESET = 8;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEFAULT_VALUE = 2'd1;

endpackage

`default_nettype wire

### hdl/bma_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Sample ring store: one write port, one registered read port
module bma_ring #(
    parameter int DEPTH = bma_pkg::MAX_WINDOW,
    parameter int WIDTH = bma_pkg::SAMPLE_BITS
) (
    input  wire logic                     aclk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/bma_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero
module bma_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 7
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic        [DEN_W-1:0] divisor,
    output logic                         done,
    output logic signed      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] div_reg;

    logic [NUM_W-1:0] mag;
    logic [DEN_W:0]   shifted;
    logic             take;
    logic [DEN_W:0]   diff;

    // Magnitude of the dividend at start
    assign mag = dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);

    // One restoring step
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign take    = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[NUM_W-1];
            quo_reg <= mag;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

### hdl/boxcar_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

// Boxcar moving average over the last window_length signed samples (0 acts as 1,
// anything above MAX_WINDOW as MAX_WINDOW). Each input item yields one average,
// the window total divided by the length and truncated toward zero. On acceptance
// the oldest entry is read from the ring, then the ST_UPD state updates the running
// total and the ring, and then the restoring divider produces one quotient bit per
// cycle; s_tready stays low until the average is loaded into the output register,
// which also waits for that register to be free. A finished average waits in the output
// register while the next item is taken. Writing either configuration register
// refills the whole window with default_value at once, with no clearing pass;
// write it only while the block is idle.
module boxcar_moving_average #(
    parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // s_tdata: sample
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // m_tdata: average
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    // Configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic [bma_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [((SAMPLE_BITS > bma_pkg::LEN_BITS) ?
                        SAMPLE_BITS : bma_pkg::LEN_BITS)-1:0] cfg_wdata
);

    localparam int SW = SAMPLE_BITS;
    localparam int LB = bma_pkg::LEN_BITS;
    localparam int PW = $clog2(MAX_WINDOW);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int TW = SAMPLE_BITS + PW + 1;
    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int RW = (LW > LB) ? LW : LB;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_UPD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    // Clamp the raw length register to 1..MAX_WINDOW
    function automatic logic [LW-1:0] eff_len(input logic [LB-1:0] raw);
        logic [RW-1:0] r;
        r = RW'(raw);
        if (r == '0) begin
            eff_len = LW'(1);
        end else if (r > RW'(MAX_WINDOW)) begin
            eff_len = LW'(MAX_WINDOW);
        end else begin
            eff_len = LW'(r);
        end
    endfunction

    logic [1:0]           state_reg;
    logic [LB-1:0]        len_reg;
    logic signed [SW-1:0] def_reg;
    logic signed [TW-1:0] total_reg;
    logic [PW-1:0]        wp_reg;
    logic                 wrapped_reg;
    logic signed [SW-1:0] sample_reg;
    logic [SW-1:0]        avg_reg;
    logic                 m_tvalid_reg;

    logic                 s_accept;
    logic                 cfg_hit;
    logic [LB-1:0]        len_next;
    logic signed [SW-1:0] def_next;
    logic signed [TW-1:0] def_x;
    logic signed [TW-1:0] len_x;
    logic signed [TW-1:0] fill_total;
    logic [LW-1:0]        eff;
    logic [SW-1:0]        rd_data;
    logic signed [SW-1:0] old_val;
    logic signed [TW-1:0] total_next;
    logic [LW-1:0]        wp_inc;
    logic                 wp_wrap;
    logic                 div_done;
    logic signed [TW-1:0] div_q;
    logic                 out_free;
    logic                 out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign eff      = eff_len(len_reg);

    // Configuration decode and refill total
    assign cfg_hit  = cfg_we && ((cfg_index == bma_pkg::CFG_WINDOW_LENGTH) ||
                                 (cfg_index == bma_pkg::CFG_DEFAULT_VALUE));
    assign len_next = (cfg_we && cfg_index == bma_pkg::CFG_WINDOW_LENGTH) ?
                      cfg_wdata[LB-1:0] : len_reg;
    assign def_next = (cfg_we && cfg_index == bma_pkg::CFG_DEFAULT_VALUE) ?
                      $signed(cfg_wdata[SW-1:0]) : def_reg;
    assign def_x      = TW'(def_next);
    assign len_x      = $signed(TW'(eff_len(len_next)));
    assign fill_total = def_x * len_x;

    // Running total update; entries not yet written since refill read as default
    assign old_val    = wrapped_reg ? $signed(rd_data) : def_reg;
    assign total_next = total_reg - TW'(old_val) + TW'(sample_reg);

    // Write position advance
    assign wp_inc  = LW'(wp_reg) + LW'(1);
    assign wp_wrap = (wp_inc >= eff);

    // Output register handshake
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_DIV) && div_done && out_free;

    bma_ring #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SW)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (wp_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_UPD),
        .wr_addr (wp_reg),
        .wr_data (sample_reg)
    );

    bma_div #(
        .NUM_W (TW),
        .DEN_W (LW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_UPD),
        .dividend (total_next),
        .divisor  (eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= LB'(bma_pkg::LEN_RESET);
            def_reg      <= '0;
            total_reg    <= '0;
            wp_reg       <= '0;
            wrapped_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    total_reg <= total_next;
                    if (wp_wrap) begin
                        wp_reg      <= '0;
                        wrapped_reg <= 1'b1;
                    end else begin
                        wp_reg <= PW'(wp_inc);
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Refill on a write to either configuration register
            if (cfg_hit) begin
                len_reg     <= len_next;
                def_reg     <= def_next;
                total_reg   <= fill_total;
                wp_reg      <= '0;
                wrapped_reg <= 1'b0;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= $signed(s_tdata[SW-1:0]);
        end
        if (out_load) begin
            avg_reg <= div_q[SW-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DW'(avg_reg);

endmodule

`default_nettype wire

### hdl/bma_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the moving average block
module bma_checker #(
    parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

    // Out of reset the block is idle and holds no result
    `ASSERT_CLK(a_reset_idle, aclk, !aresetn |=> s_tready && !m_tvalid, "not idle after reset")

    // An accepted item keeps the input closed while it is worked on
    `ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "ready right after accept")

    // A pending result is not dropped
    `ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")

    // A stalled result keeps its value
    `ASSERT_RST(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

endmodule

bind boxcar_moving_average bma_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_bma_checker (.*);

`default_nettype wire
